/* rtl/spr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spr_pkg: shared types and constants for stereo pinhole reprojection
// Fixed-point formats, stage word widths, register indexes and result codes.
// ----------------------------------------------------------------------------
package spr_pkg;

	localparam int PIXEL_FRAC_BITS = 12;
	localparam int ROT_FRAC_BITS   = 18;

	localparam int ENTRY_W  = 20;                 // one rotation entry
	localparam int ROW_W    = 3 * ENTRY_W;        // packed rotation row
	localparam int COORD_W  = 32;                 // world point, translation
	localparam int REG_W    = 32;                 // focal, center, baseline
	localparam int PIX_W    = 32;                 // output pixel fields
	localparam int LIMIT_W  = 2 * PIX_W;          // packed min/max pair

	localparam int PROD_W   = ENTRY_W + COORD_W;
	localparam int SHIFT_W  = COORD_W + ROT_FRAC_BITS;
	localparam int CAM_W    = ((PROD_W > SHIFT_W) ? PROD_W : SHIFT_W) + 2;
	localparam int DEP_W    = CAM_W - 1;          // positive depth magnitude
	localparam int MAG_LO_W = CAM_W / 2;
	localparam int MAG_HI_W = CAM_W - MAG_LO_W;
	localparam int NUM_W    = REG_W + CAM_W;      // dividend width
	localparam int QUOT_W   = 40;                 // quotient clamps to 2^40-1
	localparam int HI_W     = NUM_W - QUOT_W;
	localparam int DISP_SHIFT = ROT_FRAC_BITS + PIXEL_FRAC_BITS;
	localparam int PX_W     = QUOT_W + 2;         // signed quotient plus center
	localparam int RX_W     = QUOT_W + 3;         // px minus disparity
	localparam int DIV_STEPS = QUOT_W;
	localparam int NUM_LANES = 3;
	localparam int LANE_X = 0;
	localparam int LANE_Y = 1;
	localparam int LANE_D = 2;

	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	localparam logic [2:0] REG_FOCAL_X   = 3'd0;
	localparam logic [2:0] REG_FOCAL_Y   = 3'd1;
	localparam logic [2:0] REG_CENTER_X  = 3'd2;
	localparam logic [2:0] REG_CENTER_Y  = 3'd3;
	localparam logic [2:0] REG_BASELINE  = 3'd4;
	localparam logic [2:0] REG_X_LIMITS  = 3'd5;
	localparam logic [2:0] REG_Y_LIMITS  = 3'd6;

	localparam logic [REG_W-1:0] FOCAL_RESET = 32'd2097152;

	localparam logic signed [RX_W-1:0] SAT_MAX = RX_W'(2147483647);
	localparam logic signed [RX_W-1:0] SAT_MIN = -SAT_MAX - 1;

	typedef enum logic [1:0] {
		ST_VISIBLE = 2'd0,
		ST_BEHIND  = 2'd1,
		ST_OUTSIDE = 2'd2
	} spr_status_t;

	typedef struct packed {
		logic [REG_W-1:0]   focal_x;
		logic [REG_W-1:0]   focal_y;
		logic [REG_W-1:0]   center_x;
		logic [REG_W-1:0]   center_y;
		logic [REG_W-1:0]   focal_baseline;
		logic [LIMIT_W-1:0] x_limits;
		logic [LIMIT_W-1:0] y_limits;
	} spr_cfg_t;

	typedef struct packed {
		logic behind;
		logic neg_x;
		logic neg_y;
	} spr_side_t;

	// divider lane: partial remainder, dividend bits still to shift in
	// (quotient bits fill in from the bottom), overflow flag
	typedef struct packed {
		logic             ovf;
		logic [DEP_W-1:0] rem;
		logic [QUOT_W-1:0] low;
	} spr_lane_t;

	typedef struct packed {
		spr_status_t      status;
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
		logic [PIX_W-1:0] right_x;
	} spr_result_t;

endpackage
`default_nettype wire

/* rtl/stereo_pinhole_reprojection.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_pinhole_reprojection: fixed-point pinhole projection, one point per item
// Each item: pose (rotation rows, translation) and a world point; result: status
// and left/right pixel coordinates.
//
// Input channel in_valid/in_ready carries the item fields; output channel
// out_valid/out_ready carries status, pixel_x, pixel_y, right_x. One item is
// taken per cycle while the skid register is empty; the sustained rate is one
// item per clock while out_ready stays high. Pipeline: 3 transform stages,
// 3 focal/dividend stages, 40 divider stages (one quotient bit each, set by
// the 40-bit quotient range), 1 pixel assembly stage and the output register.
// The whole pipeline advances on one enable. A skid register behind the output
// register takes one more result when the receiver stalls, so in_ready only
// drops once both hold an item; no item is lost or repeated.
// Configuration: APB-style, 64-bit data, register i at byte address 8*i, written
// on psel && penable && pwrite (pready tied high). Write only while idle.
// Reset clears all valid bits and loads register reset values (focal 512.0).
// ----------------------------------------------------------------------------
module stereo_pinhole_reprojection (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [spr_pkg::ADDR_W-1:0]        paddr,
	input  wire logic [spr_pkg::DATA_W-1:0]        pwdata,
	output logic [spr_pkg::DATA_W-1:0]             prdata,
	output logic                                   pready,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [spr_pkg::ROW_W-1:0]         rotation_row_0,
	input  wire logic [spr_pkg::ROW_W-1:0]         rotation_row_1,
	input  wire logic [spr_pkg::ROW_W-1:0]         rotation_row_2,
	input  wire logic signed [spr_pkg::COORD_W-1:0] shift_x,
	input  wire logic signed [spr_pkg::COORD_W-1:0] shift_y,
	input  wire logic signed [spr_pkg::COORD_W-1:0] shift_z,
	input  wire logic signed [spr_pkg::COORD_W-1:0] point_x,
	input  wire logic signed [spr_pkg::COORD_W-1:0] point_y,
	input  wire logic signed [spr_pkg::COORD_W-1:0] point_z,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [1:0]                             status,
	output logic signed [spr_pkg::PIX_W-1:0]       pixel_x,
	output logic signed [spr_pkg::PIX_W-1:0]       pixel_y,
	output logic signed [spr_pkg::PIX_W-1:0]       right_x
);
	import spr_pkg::*;

	spr_cfg_t     cfg_q;
	logic [2:0]   reg_idx;

	logic         en;
	logic         valid_s3, valid_s6, div_valid, fin_valid;
	logic [CAM_W-1:0] mag_x_s3, mag_y_s3;
	logic [DEP_W-1:0] depth_s3, depth_s6;
	spr_side_t    side_s3, side_s6, div_side;
	spr_lane_t    lane_s6 [NUM_LANES];
	logic [QUOT_W-1:0] quot [NUM_LANES];
	spr_result_t  fin_res;

	logic         out_v_q, skid_v_q;
	spr_result_t  out_q, skid_q;

	// ---------------- configuration port ----------------
	assign reg_idx = paddr[ADDR_W-1:3];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_x        <= FOCAL_RESET;
			cfg_q.focal_y        <= FOCAL_RESET;
			cfg_q.center_x       <= '0;
			cfg_q.center_y       <= '0;
			cfg_q.focal_baseline <= '0;
			cfg_q.x_limits       <= '0;
			cfg_q.y_limits       <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_FOCAL_X:  cfg_q.focal_x        <= pwdata[REG_W-1:0];
				REG_FOCAL_Y:  cfg_q.focal_y        <= pwdata[REG_W-1:0];
				REG_CENTER_X: cfg_q.center_x       <= pwdata[REG_W-1:0];
				REG_CENTER_Y: cfg_q.center_y       <= pwdata[REG_W-1:0];
				REG_BASELINE: cfg_q.focal_baseline <= pwdata[REG_W-1:0];
				REG_X_LIMITS: cfg_q.x_limits       <= pwdata[LIMIT_W-1:0];
				REG_Y_LIMITS: cfg_q.y_limits       <= pwdata[LIMIT_W-1:0];
				default: ;  // unmapped address: ignored
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FOCAL_X:  prdata = DATA_W'(cfg_q.focal_x);
			REG_FOCAL_Y:  prdata = DATA_W'(cfg_q.focal_y);
			REG_CENTER_X: prdata = DATA_W'(cfg_q.center_x);
			REG_CENTER_Y: prdata = DATA_W'(cfg_q.center_y);
			REG_BASELINE: prdata = DATA_W'(cfg_q.focal_baseline);
			REG_X_LIMITS: prdata = DATA_W'(cfg_q.x_limits);
			REG_Y_LIMITS: prdata = DATA_W'(cfg_q.y_limits);
			default:      prdata = '0;
		endcase
	end

	// ---------------- pipeline ----------------
	// whole pipe moves unless the skid register is occupied
	assign en       = !skid_v_q;
	assign in_ready = en;

	spr_transform u_transform (
		.clk, .arst_n, .en, .in_valid,
		.rotation_row_0, .rotation_row_1, .rotation_row_2,
		.shift_x, .shift_y, .shift_z, .point_x, .point_y, .point_z,
		.valid_s3, .mag_x_s3, .mag_y_s3, .depth_s3, .side_s3
	);

	spr_scale u_scale (
		.clk, .arst_n, .en, .cfg(cfg_q),
		.valid_s3, .mag_x_s3, .mag_y_s3, .depth_s3, .side_s3,
		.valid_s6, .lane_s6, .depth_s6, .side_s6
	);

	spr_divider u_divider (
		.clk, .arst_n, .en,
		.valid_i(valid_s6), .lane_i(lane_s6), .depth_i(depth_s6), .side_i(side_s6),
		.valid_o(div_valid), .quot_o(quot), .side_o(div_side)
	);

	spr_finish u_finish (
		.clk, .arst_n, .en, .cfg(cfg_q),
		.valid_i(div_valid), .quot_i(quot), .side_i(div_side),
		.valid_f1(fin_valid), .result(fin_res)
	);

	// ---------------- output register and skid ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q  <= fin_valid;
			end
		end else if (fin_valid && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			out_q <= skid_v_q ? skid_q : fin_res;
		end else if (fin_valid && en) begin
			skid_q <= fin_res;
		end
	end

	assign out_valid = out_v_q;
	assign status    = out_q.status;
	assign pixel_x   = out_q.pixel_x;
	assign pixel_y   = out_q.pixel_y;
	assign right_x   = out_q.right_x;

`ifndef ASSERT_OFF
	// skid only ever fills behind a held output item
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register holds an item while output is empty");

	// behind-camera results carry zero pixels
	a_behind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_BEHIND) |->
		(pixel_x == 0 && pixel_y == 0 && right_x == 0))
		else $error("behind-camera item with nonzero pixel fields");

	// monocular setup: no disparity
	a_mono_right: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_BEHIND && cfg_q.focal_baseline == 0) |->
		(right_x == pixel_x))
		else $error("right_x differs from pixel_x with zero baseline");
`endif

endmodule
`default_nettype wire

/* rtl/spr_transform.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spr_transform: world to camera frame
// Rotation products, translation sum, then depth test and coordinate magnitudes.
// ----------------------------------------------------------------------------
module spr_transform (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [spr_pkg::ROW_W-1:0]     rotation_row_0,
	input  wire logic [spr_pkg::ROW_W-1:0]     rotation_row_1,
	input  wire logic [spr_pkg::ROW_W-1:0]     rotation_row_2,
	input  wire logic signed [spr_pkg::COORD_W-1:0] shift_x,
	input  wire logic signed [spr_pkg::COORD_W-1:0] shift_y,
	input  wire logic signed [spr_pkg::COORD_W-1:0] shift_z,
	input  wire logic signed [spr_pkg::COORD_W-1:0] point_x,
	input  wire logic signed [spr_pkg::COORD_W-1:0] point_y,
	input  wire logic signed [spr_pkg::COORD_W-1:0] point_z,
	output logic                               valid_s3,
	output logic [spr_pkg::CAM_W-1:0]          mag_x_s3,
	output logic [spr_pkg::CAM_W-1:0]          mag_y_s3,
	output logic [spr_pkg::DEP_W-1:0]          depth_s3,
	output spr_pkg::spr_side_t                 side_s3
);
	import spr_pkg::*;

	logic [ROW_W-1:0]          rows [3];
	logic signed [COORD_W-1:0] pt [3];
	logic signed [COORD_W-1:0] sh [3];

	logic                      valid_s1, valid_s2;
	logic signed [PROD_W-1:0]  prod_s1 [3][3];
	logic signed [COORD_W-1:0] shift_s1 [3];
	logic signed [CAM_W-1:0]   cam_s2 [3];

	always_comb begin
		rows[0] = rotation_row_0;
		rows[1] = rotation_row_1;
		rows[2] = rotation_row_2;
		pt[0] = point_x;
		pt[1] = point_y;
		pt[2] = point_z;
		sh[0] = shift_x;
		sh[1] = shift_y;
		sh[2] = shift_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= $signed(rows[r][ENTRY_W*c +: ENTRY_W]) * pt[c];
				end
				shift_s1[r] <= sh[r];
				cam_s2[r] <= (CAM_W'(shift_s1[r]) <<< ROT_FRAC_BITS)
					+ CAM_W'(prod_s1[r][0]) + CAM_W'(prod_s1[r][1])
					+ CAM_W'(prod_s1[r][2]);
			end
			side_s3.behind <= (cam_s2[2] <= 0);
			side_s3.neg_x  <= cam_s2[0][CAM_W-1];
			side_s3.neg_y  <= cam_s2[1][CAM_W-1];
			mag_x_s3 <= cam_s2[0][CAM_W-1] ? CAM_W'(-cam_s2[0]) : CAM_W'(cam_s2[0]);
			mag_y_s3 <= cam_s2[1][CAM_W-1] ? CAM_W'(-cam_s2[1]) : CAM_W'(cam_s2[1]);
			depth_s3 <= cam_s2[2][DEP_W-1:0];
		end
	end

endmodule
`default_nettype wire

/* rtl/spr_scale.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spr_scale: dividend build-up
// Focal products in split partials, dividend sums, overflow test against depth.
// ----------------------------------------------------------------------------
module spr_scale (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire spr_pkg::spr_cfg_t        cfg,
	input  wire logic                     valid_s3,
	input  wire logic [spr_pkg::CAM_W-1:0] mag_x_s3,
	input  wire logic [spr_pkg::CAM_W-1:0] mag_y_s3,
	input  wire logic [spr_pkg::DEP_W-1:0] depth_s3,
	input  wire spr_pkg::spr_side_t       side_s3,
	output logic                          valid_s6,
	output spr_pkg::spr_lane_t            lane_s6 [spr_pkg::NUM_LANES],
	output logic [spr_pkg::DEP_W-1:0]     depth_s6,
	output spr_pkg::spr_side_t            side_s6
);
	import spr_pkg::*;

	logic                        valid_s4, valid_s5;
	logic [REG_W+MAG_LO_W-1:0]   lo_x_s4, lo_y_s4;
	logic [REG_W+MAG_HI_W-1:0]   hi_x_s4, hi_y_s4;
	logic [DEP_W-1:0]            depth_s4, depth_s5;
	spr_side_t                   side_s4, side_s5;
	logic [NUM_W-1:0]            num_s5 [NUM_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_x_s4  <= cfg.focal_x * mag_x_s3[MAG_LO_W-1:0];
			hi_x_s4  <= cfg.focal_x * mag_x_s3[CAM_W-1:MAG_LO_W];
			lo_y_s4  <= cfg.focal_y * mag_y_s3[MAG_LO_W-1:0];
			hi_y_s4  <= cfg.focal_y * mag_y_s3[CAM_W-1:MAG_LO_W];
			depth_s4 <= depth_s3;
			side_s4  <= side_s3;

			num_s5[LANE_X] <= NUM_W'(lo_x_s4) + (NUM_W'(hi_x_s4) << MAG_LO_W);
			num_s5[LANE_Y] <= NUM_W'(lo_y_s4) + (NUM_W'(hi_y_s4) << MAG_LO_W);
			num_s5[LANE_D] <= NUM_W'(cfg.focal_baseline) << DISP_SHIFT;
			depth_s5 <= depth_s4;
			side_s5  <= side_s4;

			for (int l = 0; l < NUM_LANES; l++) begin
				// quotient reaches 2^40 exactly when the upper dividend part >= depth
				lane_s6[l].ovf <= (DEP_W'(num_s5[l][NUM_W-1:QUOT_W]) >= depth_s5);
				lane_s6[l].rem <= DEP_W'(num_s5[l][NUM_W-1:QUOT_W]);
				lane_s6[l].low <= num_s5[l][QUOT_W-1:0];
			end
			depth_s6 <= depth_s5;
			side_s6  <= side_s5;
		end
	end

endmodule
`default_nettype wire

/* rtl/spr_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spr_divider: pipelined restoring divider, three lanes sharing one divisor
// One quotient bit per stage; overflowed lanes clamp to all ones.
// ----------------------------------------------------------------------------
module spr_divider (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      valid_i,
	input  wire spr_pkg::spr_lane_t        lane_i [spr_pkg::NUM_LANES],
	input  wire logic [spr_pkg::DEP_W-1:0] depth_i,
	input  wire spr_pkg::spr_side_t        side_i,
	output logic                           valid_o,
	output logic [spr_pkg::QUOT_W-1:0]     quot_o [spr_pkg::NUM_LANES],
	output spr_pkg::spr_side_t             side_o
);
	import spr_pkg::*;

	logic             valid_s [DIV_STEPS];
	spr_lane_t        lane_s  [DIV_STEPS][NUM_LANES];
	logic [DEP_W-1:0] depth_s [DIV_STEPS-1];
	spr_side_t        side_s  [DIV_STEPS];

	function automatic spr_lane_t div_step(input spr_lane_t l, input logic [DEP_W-1:0] d);
		logic [DEP_W:0] t;
		logic           qb;
		spr_lane_t      o;
		t  = {l.rem, l.low[QUOT_W-1]};
		qb = (t >= {1'b0, d});
		if (qb) begin
			t = t - {1'b0, d};
		end
		o.ovf = l.ovf;
		o.rem = t[DEP_W-1:0];
		o.low = {l.low[QUOT_W-2:0], qb};
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STEPS; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (en) begin
			valid_s[0] <= valid_i;
			for (int k = 1; k < DIV_STEPS; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				lane_s[0][l] <= div_step(lane_i[l], depth_i);
			end
			depth_s[0] <= depth_i;
			side_s[0]  <= side_i;
			for (int k = 1; k < DIV_STEPS; k++) begin
				for (int l = 0; l < NUM_LANES; l++) begin
					lane_s[k][l] <= div_step(lane_s[k-1][l], depth_s[k-1]);
				end
				if (k < DIV_STEPS - 1) begin
					depth_s[k] <= depth_s[k-1];
				end
				side_s[k] <= side_s[k-1];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			quot_o[l] = lane_s[DIV_STEPS-1][l].ovf ? {QUOT_W{1'b1}}
				: lane_s[DIV_STEPS-1][l].low;
		end
	end

	assign valid_o = valid_s[DIV_STEPS-1];
	assign side_o  = side_s[DIV_STEPS-1];

endmodule
`default_nettype wire

/* rtl/spr_finish.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spr_finish: pixel assembly
// Signed quotient plus center, disparity, bounds test and saturation.
// ----------------------------------------------------------------------------
module spr_finish (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire spr_pkg::spr_cfg_t     cfg,
	input  wire logic                  valid_i,
	input  wire logic [spr_pkg::QUOT_W-1:0] quot_i [spr_pkg::NUM_LANES],
	input  wire spr_pkg::spr_side_t    side_i,
	output logic                       valid_f1,
	output spr_pkg::spr_result_t       result
);
	import spr_pkg::*;

	logic signed [PX_W-1:0] qx, qy, cx, cy;
	logic signed [PX_W-1:0] px_f1, py_f1;
	logic [QUOT_W-1:0]      disp_f1;
	logic                   behind_f1;

	logic signed [RX_W-1:0] rx;
	logic signed [PX_W-1:0] min_x, max_x, min_y, max_y;
	logic                   outside;

	function automatic logic [PIX_W-1:0] sat32(input logic signed [RX_W-1:0] v);
		if (v > SAT_MAX) begin
			return SAT_MAX[PIX_W-1:0];
		end else if (v < SAT_MIN) begin
			return SAT_MIN[PIX_W-1:0];
		end
		return v[PIX_W-1:0];
	endfunction

	assign qx = $signed({2'b00, quot_i[LANE_X]});
	assign qy = $signed({2'b00, quot_i[LANE_Y]});
	assign cx = PX_W'($signed(cfg.center_x));
	assign cy = PX_W'($signed(cfg.center_y));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_f1 <= 1'b0;
		end else if (en) begin
			valid_f1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_f1     <= (side_i.neg_x ? -qx : qx) + cx;
			py_f1     <= (side_i.neg_y ? -qy : qy) + cy;
			disp_f1   <= quot_i[LANE_D];
			behind_f1 <= side_i.behind;
		end
	end

	always_comb begin
		rx    = RX_W'(px_f1) - RX_W'($signed({1'b0, disp_f1}));
		min_x = PX_W'($signed(cfg.x_limits[PIX_W-1:0]));
		max_x = PX_W'($signed(cfg.x_limits[LIMIT_W-1:PIX_W]));
		min_y = PX_W'($signed(cfg.y_limits[PIX_W-1:0]));
		max_y = PX_W'($signed(cfg.y_limits[LIMIT_W-1:PIX_W]));
		outside = (px_f1 < min_x) || (px_f1 > max_x) || (py_f1 < min_y) || (py_f1 > max_y);
		if (behind_f1) begin
			result.status  = ST_BEHIND;
			result.pixel_x = '0;
			result.pixel_y = '0;
			result.right_x = '0;
		end else begin
			result.status  = outside ? ST_OUTSIDE : ST_VISIBLE;
			result.pixel_x = sat32(RX_W'(px_f1));
			result.pixel_y = sat32(RX_W'(py_f1));
			result.right_x = sat32(rx);
		end
	end

endmodule
`default_nettype wire
